// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the transfer engine
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define FOE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define FOE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define FOE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define FOE_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/foe_pkg.sv =====
// ----------------------------------------------------------------------------
// foe_pkg
// types and protocol constants of the file transfer engine
// ----------------------------------------------------------------------------
package foe_pkg;

  localparam logic [1:0] REQ_REPLY  = 2'd0;
  localparam logic [1:0] REQ_SENT   = 2'd1;
  localparam logic [1:0] REQ_CANCEL = 2'd2;

  localparam logic [1:0] ACT_IGNORE   = 2'd0;
  localparam logic [1:0] ACT_CONTINUE = 2'd1;
  localparam logic [1:0] ACT_FINISHED = 2'd2;

  localparam logic [2:0] ST_RUNNING   = 3'd0;
  localparam logic [2:0] ST_SUCCESS   = 3'd1;
  localparam logic [2:0] ST_INVALID   = 3'd2;
  localparam logic [2:0] ST_BADNUM    = 3'd3;
  localparam logic [2:0] ST_BADOP     = 3'd4;
  localparam logic [2:0] ST_CANCELLED = 3'd5;
  localparam logic [2:0] ST_SLAVE_ERR = 3'd6;

  localparam logic [7:0] OP_DATA  = 8'd3;
  localparam logic [7:0] OP_ACK   = 8'd4;
  localparam logic [7:0] OP_ERROR = 8'd5;
  localparam logic [7:0] OP_BUSY  = 8'd6;

  localparam logic [1:0] REG_READ_MODE = 2'd0;
  localparam logic [1:0] REG_FILE_SIZE = 2'd1;
  localparam logic [1:0] REG_OUT_MBX   = 2'd2;
  localparam logic [1:0] REG_IN_MBX    = 2'd3;

  localparam logic [15:0] HDR_LEN           = 16'd6;
  localparam logic [15:0] PROTOCOL_OVERHEAD = 16'd12;
  localparam logic [3:0]  MBX_TYPE_FOE      = 4'd4;

  localparam logic [31:0] CODE_NOT_DEFINED = 32'h0000_8000;
  localparam logic [31:0] CODE_ILLEGAL     = 32'h0000_8004;
  localparam logic [31:0] CODE_BAD_NUMBER  = 32'h0000_8005;

  typedef struct packed {
    logic        read_mode;
    logic [31:0] file_size;
    logic [15:0] out_cap;
    logic [15:0] in_mbx_size;
    logic [15:0] in_full;
    logic        in_small;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic        gateway_flag;
    logic [3:0]  mailbox_kind;
    logic [15:0] reply_length;
    logic [7:0]  reply_opcode;
    logic [31:0] reply_value;
  } item_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  send_opcode;
    logic [31:0] send_value;
    logic [15:0] send_length;
    logic [31:0] data_offset;
    logic [2:0]  status;
    logic [31:0] slave_error_code;
    logic [15:0] append_length;
    logic [31:0] bytes_done;
    logic        rearm_timeout;
  } result_t;

endpackage

// ===== rtl/foe_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// foe_cfg_regs
// configuration registers with precomputed chunk capacities
// ----------------------------------------------------------------------------
module foe_cfg_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  logic [1:0]          wr_index,
  input  logic [31:0]         wr_data,
  output foe_pkg::cfg_t       cfg
);

  foe_pkg::cfg_t cfg_r;
  foe_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        foe_pkg::REG_READ_MODE: cfg_nxt.read_mode = wr_data[0];
        foe_pkg::REG_FILE_SIZE: cfg_nxt.file_size = wr_data;
        foe_pkg::REG_OUT_MBX: begin
          cfg_nxt.out_cap = (wr_data[15:0] > foe_pkg::PROTOCOL_OVERHEAD) ?
                            wr_data[15:0] - foe_pkg::PROTOCOL_OVERHEAD : 16'd0;
        end
        foe_pkg::REG_IN_MBX: begin
          cfg_nxt.in_mbx_size = wr_data[15:0];
          cfg_nxt.in_small    = wr_data[15:0] < foe_pkg::PROTOCOL_OVERHEAD;
          cfg_nxt.in_full     = wr_data[15:0] - foe_pkg::PROTOCOL_OVERHEAD;
        end
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.read_mode   <= 1'b0;
      cfg_r.file_size   <= 32'd0;
      cfg_r.out_cap     <= 16'd116;
      cfg_r.in_mbx_size <= 16'd128;
      cfg_r.in_full     <= 16'd116;
      cfg_r.in_small    <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/foe_core.sv =====
// ----------------------------------------------------------------------------
// foe_core
// transfer state and combinational event evaluation
// ----------------------------------------------------------------------------
module foe_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_en,
  input  foe_pkg::item_t       item,
  input  foe_pkg::cfg_t        cfg,
  output foe_pkg::result_t     res
);

  logic [31:0] pkt_r, pkt_nxt;
  logic [31:0] woff_r, woff_nxt;
  logic [31:0] acked_r, acked_nxt;
  logic [31:0] recv_r, recv_nxt;
  logic        last_r, last_nxt;
  logic        cancel_r, cancel_nxt;
  logic [2:0]  status_r, status_nxt;
  logic [2:0]  pend_r, pend_nxt;
  logic [7:0]  hop_r, hop_nxt;
  logic [31:0] hval_r, hval_nxt;
  logic [15:0] hlen_r, hlen_nxt;

  logic [15:0] payload;
  logic        len_bad;
  logic [31:0] pkt_inc;
  logic [31:0] rest;
  logic [15:0] chunk;
  logic        chunk_last;
  logic [1:0]  action;
  logic        rearm;
  logic [31:0] err;
  logic [15:0] append;
  logic [15:0] chunk_held;
  logic [31:0] doff;

  always_comb begin
    payload = item.reply_length - foe_pkg::HDR_LEN;
    len_bad = (item.reply_length < foe_pkg::HDR_LEN) ||
              (({1'b0, item.reply_length} + {1'b0, foe_pkg::HDR_LEN}) >
               {1'b0, cfg.in_mbx_size});
    pkt_inc = pkt_r + 32'd1;
    rest    = (cfg.file_size > woff_r) ? cfg.file_size - woff_r : 32'd0;
    chunk   = (rest < {16'd0, cfg.out_cap}) ? rest[15:0] : cfg.out_cap;
    chunk_last = chunk < cfg.out_cap;
  end

  always_comb begin
    pkt_nxt    = pkt_r;
    woff_nxt   = woff_r;
    acked_nxt  = acked_r;
    recv_nxt   = recv_r;
    last_nxt   = last_r;
    cancel_nxt = cancel_r;
    status_nxt = status_r;
    pend_nxt   = pend_r;
    hop_nxt    = hop_r;
    hval_nxt   = hval_r;
    hlen_nxt   = hlen_r;
    action     = foe_pkg::ACT_IGNORE;
    rearm      = 1'b0;
    err        = 32'd0;
    append     = 16'd0;

    case (item.req_type)
      foe_pkg::REQ_REPLY: begin
        if (status_r != foe_pkg::ST_RUNNING || item.gateway_flag ||
            item.mailbox_kind != foe_pkg::MBX_TYPE_FOE) begin
          action = foe_pkg::ACT_IGNORE;
        end else if (len_bad) begin
          status_nxt = foe_pkg::ST_INVALID;
          action     = foe_pkg::ACT_FINISHED;
        end else if (item.reply_opcode == foe_pkg::OP_ERROR) begin
          status_nxt = foe_pkg::ST_SLAVE_ERR;
          err        = item.reply_value;
          action     = foe_pkg::ACT_FINISHED;
        end else if (cancel_r) begin
          hop_nxt  = foe_pkg::OP_ERROR;
          hval_nxt = foe_pkg::CODE_NOT_DEFINED;
          hlen_nxt = foe_pkg::HDR_LEN;
          pend_nxt = foe_pkg::ST_CANCELLED;
          action   = foe_pkg::ACT_CONTINUE;
          rearm    = 1'b1;
        end else if (cfg.read_mode) begin
          action = foe_pkg::ACT_CONTINUE;
          rearm  = 1'b1;
          if (item.reply_opcode == foe_pkg::OP_DATA) begin
            if (item.reply_value != pkt_inc) begin
              hop_nxt  = foe_pkg::OP_ERROR;
              hval_nxt = foe_pkg::CODE_BAD_NUMBER;
              hlen_nxt = foe_pkg::HDR_LEN;
              pend_nxt = foe_pkg::ST_BADNUM;
            end else begin
              recv_nxt = recv_r + {16'd0, payload};
              append   = payload;
              pkt_nxt  = item.reply_value;
              if (cfg.in_small || payload < cfg.in_full) begin
                pend_nxt = foe_pkg::ST_SUCCESS;
              end
              hop_nxt  = foe_pkg::OP_ACK;
              hval_nxt = item.reply_value;
              hlen_nxt = foe_pkg::HDR_LEN;
            end
          end else if (item.reply_opcode == foe_pkg::OP_BUSY) begin
            hop_nxt  = foe_pkg::OP_ACK;
            hval_nxt = pkt_r;
            hlen_nxt = foe_pkg::HDR_LEN;
          end else begin
            hop_nxt  = foe_pkg::OP_ERROR;
            hval_nxt = foe_pkg::CODE_ILLEGAL;
            hlen_nxt = foe_pkg::HDR_LEN;
            pend_nxt = foe_pkg::ST_BADOP;
          end
        end else begin
          action = foe_pkg::ACT_CONTINUE;
          rearm  = 1'b1;
          if (item.reply_opcode == foe_pkg::OP_ACK) begin
            if (item.reply_value != pkt_r) begin
              hop_nxt  = foe_pkg::OP_ERROR;
              hval_nxt = foe_pkg::CODE_BAD_NUMBER;
              hlen_nxt = foe_pkg::HDR_LEN;
              pend_nxt = foe_pkg::ST_BADNUM;
            end else begin
              acked_nxt = woff_r;
              if (last_r) begin
                status_nxt = foe_pkg::ST_SUCCESS;
                action     = foe_pkg::ACT_FINISHED;
                rearm      = 1'b0;
              end else begin
                pkt_nxt  = pkt_inc;
                hop_nxt  = foe_pkg::OP_DATA;
                hval_nxt = pkt_inc;
                hlen_nxt = foe_pkg::HDR_LEN + chunk;
                woff_nxt = woff_r + {16'd0, chunk};
                last_nxt = chunk_last;
              end
            end
          end else if (item.reply_opcode != foe_pkg::OP_BUSY) begin
            hop_nxt  = foe_pkg::OP_ERROR;
            hval_nxt = foe_pkg::CODE_ILLEGAL;
            hlen_nxt = foe_pkg::HDR_LEN;
            pend_nxt = foe_pkg::ST_BADOP;
          end
        end
      end
      foe_pkg::REQ_SENT: begin
        if (cancel_r && status_r == foe_pkg::ST_RUNNING) begin
          hop_nxt  = foe_pkg::OP_ERROR;
          hval_nxt = foe_pkg::CODE_NOT_DEFINED;
          hlen_nxt = foe_pkg::HDR_LEN;
          pend_nxt = foe_pkg::ST_CANCELLED;
        end
        if (pend_nxt != foe_pkg::ST_RUNNING) begin
          status_nxt = pend_nxt;
        end
        action = (status_nxt != foe_pkg::ST_RUNNING) ? foe_pkg::ACT_FINISHED :
                                                        foe_pkg::ACT_IGNORE;
      end
      foe_pkg::REQ_CANCEL: begin
        cancel_nxt = 1'b1;
      end
      default: begin
        action = foe_pkg::ACT_IGNORE;
      end
    endcase
  end

  // offset of the held data chunk
  always_comb begin
    chunk_held = hlen_nxt - foe_pkg::HDR_LEN;
    doff       = 32'd0;
    if (!cfg.read_mode && hop_nxt == foe_pkg::OP_DATA && hlen_nxt >= foe_pkg::HDR_LEN) begin
      doff = woff_nxt - {16'd0, chunk_held};
    end
  end

  always_comb begin
    res.action           = action;
    res.send_opcode      = hop_nxt;
    res.send_value       = hval_nxt;
    res.send_length      = hlen_nxt;
    res.data_offset      = doff;
    res.status           = status_nxt;
    res.slave_error_code = err;
    res.append_length    = append;
    res.bytes_done       = cfg.read_mode ? recv_nxt : acked_nxt;
    res.rearm_timeout    = rearm;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pkt_r    <= 32'd0;
      woff_r   <= 32'd0;
      acked_r  <= 32'd0;
      recv_r   <= 32'd0;
      last_r   <= 1'b0;
      cancel_r <= 1'b0;
      status_r <= foe_pkg::ST_RUNNING;
      pend_r   <= foe_pkg::ST_RUNNING;
      hop_r    <= 8'd0;
      hval_r   <= 32'd0;
      hlen_r   <= 16'd0;
    end else if (step_en) begin
      pkt_r    <= pkt_nxt;
      woff_r   <= woff_nxt;
      acked_r  <= acked_nxt;
      recv_r   <= recv_nxt;
      last_r   <= last_nxt;
      cancel_r <= cancel_nxt;
      status_r <= status_nxt;
      pend_r   <= pend_nxt;
      hop_r    <= hop_nxt;
      hval_r   <= hval_nxt;
      hlen_r   <= hlen_nxt;
    end
  end

endmodule

// ===== rtl/foe_transfer_engine.sv =====
// ----------------------------------------------------------------------------
// foe_transfer_engine
// master side of a file-over-mailbox transfer, one event in, one result out
// ----------------------------------------------------------------------------
//  channel   signals                          role
//  in_       tvalid tready tuser tdata        event beats (reply, sent, cancel)
//  out_      tvalid tready tuser tdata        one result beat per event
//  cfg_      valid ready index data           register writes, always ready
//
//  an event waits in the input register and is evaluated against the transfer
//  state on its way into the result register; one beat per cycle sustained
//  while out_ is ready, bounded by the state update.
//  rst_n is synchronous and clears state, valids and configuration.
//  a stalled out_ holds its beat while one more event waits in the input stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module foe_transfer_engine (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [1:0]   in_tuser,   // req_type
  input  logic [63:0]  in_tdata,   // gateway_flag, mailbox_kind, reply_length,
                                   // reply_opcode, reply_value, zero fill
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [1:0]   out_tuser,  // action
  output logic [175:0] out_tdata,  // send_opcode, send_value, send_length,
                                   // data_offset, status, slave_error_code,
                                   // append_length, bytes_done, rearm_timeout,
                                   // zero fill
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  foe_pkg::cfg_t    cfg;
  foe_pkg::item_t   item_r;
  foe_pkg::result_t res;
  foe_pkg::result_t res_r;
  logic             in_valid_r;
  logic             out_valid_r;
  logic             step_en;
  logic             in_fire;

  assign cfg_ready = 1'b1;

  foe_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign step_en   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || step_en;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_fire || (in_valid_r && !step_en);
      if (step_en) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.req_type     <= in_tuser;
      item_r.gateway_flag <= in_tdata[0];
      item_r.mailbox_kind <= in_tdata[4:1];
      item_r.reply_length <= in_tdata[20:5];
      item_r.reply_opcode <= in_tdata[28:21];
      item_r.reply_value  <= in_tdata[60:29];
    end
    if (step_en) begin
      res_r <= res;
    end
  end

  foe_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (item_r),
    .cfg     (cfg),
    .res     (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.action;
  assign out_tdata  = {4'd0,
                       res_r.rearm_timeout,
                       res_r.bytes_done,
                       res_r.append_length,
                       res_r.slave_error_code,
                       res_r.status,
                       res_r.data_offset,
                       res_r.send_length,
                       res_r.send_value,
                       res_r.send_opcode};

  `FOE_ASSERT_IMP(a_stall_blocks_in, clk, rst_n,
                  in_valid_r && out_valid_r && !out_tready, !in_tready)
  `FOE_ASSERT_NXT(a_step_fills_out, clk, rst_n, step_en, out_valid_r)
  `FOE_ASSERT_IMP(a_finish_has_status, clk, rst_n,
                  out_valid_r && res_r.action == foe_pkg::ACT_FINISHED,
                  res_r.status != foe_pkg::ST_RUNNING)
  `FOE_ASSERT_IMP(a_rearm_on_send, clk, rst_n,
                  out_valid_r && res_r.rearm_timeout,
                  res_r.action == foe_pkg::ACT_CONTINUE)

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for foe_transfer_engine: events go in as stream beats,
// each accepted event is run through a behavioural predictor of the transfer
// state, and every result beat is compared field by field with the oldest
// prediction
// ----------------------------------------------------------------------------
module tb;
  import foe_pkg::*;

  localparam logic [1:0]  REQ_UNUSED  = 2'd3;
  localparam logic [31:0] HDR         = 32'(HDR_LEN);
  localparam logic [31:0] OVH         = 32'(PROTOCOL_OVERHEAD);
  localparam int          CYCLE_LIMIT = 200000;
  localparam int          RUN_ITEMS   = 100;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [1:0]   in_tuser = '0;
  logic [63:0]  in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [1:0]   out_tuser;
  logic [175:0] out_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  foe_transfer_engine u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // register copies
  logic        cfg_read = 1'b0;
  logic [31:0] cfg_fsize = '0;
  logic [15:0] cfg_out_mbx = 16'd128;
  logic [15:0] cfg_in_mbx = 16'd128;

  // transfer state
  logic [31:0] pkt_num = '0;
  logic [31:0] wr_offset = '0;
  logic [31:0] acked = '0;
  logic [31:0] received = '0;
  logic        last_chunk = 1'b0;
  logic        cancel_req = 1'b0;
  logic [2:0]  cur_status = ST_RUNNING;
  logic [2:0]  pend_status = ST_RUNNING;
  logic [7:0]  held_op = '0;
  logic [31:0] held_val = '0;
  logic [15:0] held_len = '0;

  item_t   events_queued[$];
  result_t results_due[$];

  int cycle_count = 0;
  int fail_count = 0;
  int events_taken = 0;
  bit beat_taken = 1'b0;
  int gap_left = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_left = 0;
  bit long_hold = 1'b0;

  function automatic void hold_message(logic [7:0] op, logic [31:0] val, logic [31:0] payload);
    held_op = op;
    held_val = val;
    held_len = 16'(HDR + payload);
  endfunction

  function automatic void prepare_abort(logic [31:0] code, logic [2:0] st);
    hold_message(OP_ERROR, code, 32'd0);
    pend_status = st;
  endfunction

  function automatic result_t predict_transfer(item_t ev);
    result_t     r;
    logic [31:0] len, payload, cap, rest, chunk;
    r = '0;
    len = 32'(ev.reply_length);
    payload = len - HDR;
    case (ev.req_type)
      REQ_REPLY: begin
        if (cur_status != ST_RUNNING || ev.gateway_flag || ev.mailbox_kind != MBX_TYPE_FOE) begin
          r.action = ACT_IGNORE;
        end else if (len < HDR || HDR + len > 32'(cfg_in_mbx)) begin
          cur_status = ST_INVALID;
          r.action = ACT_FINISHED;
        end else if (ev.reply_opcode == OP_ERROR) begin
          cur_status = ST_SLAVE_ERR;
          r.slave_error_code = ev.reply_value;
          r.action = ACT_FINISHED;
        end else begin
          r.action = ACT_CONTINUE;
          r.rearm_timeout = 1'b1;
          if (cancel_req) begin
            prepare_abort(CODE_NOT_DEFINED, ST_CANCELLED);
          end else if (cfg_read) begin
            if (ev.reply_opcode == OP_DATA && ev.reply_value != pkt_num + 32'd1) begin
              prepare_abort(CODE_BAD_NUMBER, ST_BADNUM);
            end else if (ev.reply_opcode == OP_DATA) begin
              received = received + payload;
              r.append_length = payload[15:0];
              pkt_num = ev.reply_value;
              if (payload < 32'(cfg_in_mbx) - OVH) pend_status = ST_SUCCESS;
              hold_message(OP_ACK, pkt_num, 32'd0);
            end else if (ev.reply_opcode == OP_BUSY) begin
              hold_message(OP_ACK, pkt_num, 32'd0);
            end else begin
              prepare_abort(CODE_ILLEGAL, ST_BADOP);
            end
          end else begin
            if (ev.reply_opcode == OP_ACK && ev.reply_value != pkt_num) begin
              prepare_abort(CODE_BAD_NUMBER, ST_BADNUM);
            end else if (ev.reply_opcode == OP_ACK) begin
              acked = wr_offset;
              if (last_chunk) begin
                cur_status = ST_SUCCESS;
                r.action = ACT_FINISHED;
                r.rearm_timeout = 1'b0;
              end else begin
                cap = (32'(cfg_out_mbx) > OVH) ? 32'(cfg_out_mbx) - OVH : 32'd0;
                rest = (cfg_fsize > wr_offset) ? cfg_fsize - wr_offset : 32'd0;
                chunk = (rest < cap) ? rest : cap;
                pkt_num = pkt_num + 32'd1;
                hold_message(OP_DATA, pkt_num, chunk);
                wr_offset = wr_offset + chunk;
                last_chunk = chunk < cap;
              end
            end else if (ev.reply_opcode != OP_BUSY) begin
              prepare_abort(CODE_ILLEGAL, ST_BADOP);
            end
          end
        end
      end
      REQ_SENT: begin
        if (cancel_req && cur_status == ST_RUNNING) begin
          hold_message(OP_ERROR, CODE_NOT_DEFINED, 32'd0);
          pend_status = ST_CANCELLED;
        end
        if (pend_status != ST_RUNNING) cur_status = pend_status;
        r.action = (cur_status != ST_RUNNING) ? ACT_FINISHED : ACT_IGNORE;
      end
      REQ_CANCEL: cancel_req = 1'b1;
      default: r.action = ACT_IGNORE;
    endcase
    r.send_opcode = held_op;
    r.send_value = held_val;
    r.send_length = held_len;
    if (!cfg_read && held_op == OP_DATA && 32'(held_len) >= HDR)
      r.data_offset = wr_offset - (32'(held_len) - HDR);
    r.status = cur_status;
    r.bytes_done = cfg_read ? received : acked;
    return r;
  endfunction

  function automatic item_t make_event(logic [1:0] req, logic gw, logic [3:0] kind,
                                       logic [15:0] len, logic [7:0] op, logic [31:0] val);
    item_t ev;
    ev.req_type = req;
    ev.gateway_flag = gw;
    ev.mailbox_kind = kind;
    ev.reply_length = len;
    ev.reply_opcode = op;
    ev.reply_value = val;
    return ev;
  endfunction

  function automatic item_t foe_reply(logic [15:0] len, logic [7:0] op, logic [31:0] val);
    return make_event(REQ_REPLY, 1'b0, MBX_TYPE_FOE, len, op, val);
  endfunction

  function automatic item_t control_event(logic [1:0] req);
    return make_event(req, 1'($urandom), 4'($urandom), 16'($urandom), 8'($urandom), $urandom);
  endfunction

  // replies the block must ignore: gateway marker, foreign mailbox, unused request
  function automatic item_t noise_event();
    item_t      ev;
    logic [3:0] kind;
    ev = control_event(REQ_REPLY);
    case ($urandom_range(0, 2))
      0: ev.gateway_flag = 1'b1;
      1: begin
        kind = 4'($urandom_range(0, 14));
        if (kind >= MBX_TYPE_FOE) kind = kind + 4'd1;
        ev.mailbox_kind = kind;
      end
      default: ev.req_type = REQ_UNUSED;
    endcase
    return ev;
  endfunction

  function automatic logic [15:0] valid_len();
    return 16'($urandom_range(32'(cfg_in_mbx) - HDR, HDR));
  endfunction

  function automatic logic [15:0] full_len();
    return 16'(32'(cfg_in_mbx) - HDR);
  endfunction

  function automatic logic [15:0] pick_mbx_size();
    case ($urandom_range(0, 3))
      0: return 16'd16;
      1: return 16'hFFFF;
      2: return 16'd128;
      default: return 16'($urandom_range(16, 65535));
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_READ_MODE: cfg_read = val[0];
      REG_FILE_SIZE: cfg_fsize = val;
      REG_OUT_MBX:   cfg_out_mbx = val[15:0];
      default:       cfg_in_mbx = val[15:0];
    endcase
  endtask

  task automatic set_config(logic rm, logic [31:0] fs, logic [15:0] om, logic [15:0] im);
    write_reg(REG_READ_MODE, 32'(rm));
    write_reg(REG_FILE_SIZE, fs);
    write_reg(REG_OUT_MBX, 32'(om));
    write_reg(REG_IN_MBX, 32'(im));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (events_queued.size() != 0 || results_due.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("foe_transfer_engine: mismatch");
      $finish;
    end
  end

  // event beats taken at the rising edge
  always @(posedge clk) begin : event_accept
    if (rst_n && in_tvalid && in_tready) begin
      results_due.push_back(predict_transfer(events_queued.pop_front()));
      events_taken++;
      beat_taken = 1'b1;
    end
  end

  always @(negedge clk) begin : driver
    item_t ev;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || beat_taken) begin
      beat_taken = 1'b0;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      end
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (events_queued.size() == 0) begin
        in_tvalid <= 1'b0;
      end else begin
        ev = events_queued[0];
        in_tvalid <= 1'b1;
        in_tuser <= ev.req_type;
        in_tdata <= {3'b000, ev.reply_value, ev.reply_opcode, ev.reply_length,
                     ev.mailbox_kind, ev.gateway_flag};
        burst_left--;
      end
    end
  end

  always @(negedge clk) begin : receiver
    logic ready;
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(16, 96);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: ready = 1'b1;
      1: ready = 1'($urandom);
      2: ready = ($urandom_range(0, 3) == 0);
      default: ready = (cycle_count % 5) != 0;
    endcase
    out_tready <= ready && !long_hold;
  end

  // one long back-pressure stretch so the input side fills up
  initial begin : hold_off
    while (events_taken < 250) @(posedge clk);
    long_hold = 1'b1;
    repeat (400) @(posedge clk);
    long_hold = 1'b0;
  end

  always @(posedge clk) begin : monitor
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (results_due.size() == 0) begin
        $error("result beat with no event outstanding");
        fail_count++;
      end else begin
        want = results_due.pop_front();
        check_field("action", 32'(want.action), 32'(out_tuser));
        check_field("send_opcode", 32'(want.send_opcode), 32'(out_tdata[7:0]));
        check_field("send_value", want.send_value, out_tdata[39:8]);
        check_field("send_length", 32'(want.send_length), 32'(out_tdata[55:40]));
        check_field("data_offset", want.data_offset, out_tdata[87:56]);
        check_field("status", 32'(want.status), 32'(out_tdata[90:88]));
        check_field("slave_error_code", want.slave_error_code, out_tdata[122:91]);
        check_field("append_length", 32'(want.append_length), 32'(out_tdata[138:123]));
        check_field("bytes_done", want.bytes_done, out_tdata[170:139]);
        check_field("rearm_timeout", 32'(want.rearm_timeout), 32'(out_tdata[171]));
      end
    end
  end

  initial begin : stimulus
    logic [31:0] gen_pkt;
    logic        rm;
    logic [31:0] fs;
    logic [7:0]  op;
    logic [15:0] len;
    int          counted, pick, ending;
    gen_pkt = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: write mode at the extremes, then read mode with tiny mailboxes
    set_config(1'b0, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    events_queued.push_back(control_event(REQ_SENT));
    events_queued.push_back(make_event(REQ_REPLY, 1'b1, MBX_TYPE_FOE, 16'hFFFF, 8'hFF,
                                       32'hFFFF_FFFF));
    events_queued.push_back(make_event(REQ_REPLY, 1'b0, 4'hF, 16'd0, 8'd0, 32'd0));
    events_queued.push_back(make_event(REQ_UNUSED, 1'b1, 4'hF, 16'hFFFF, 8'hFF,
                                       32'hFFFF_FFFF));
    events_queued.push_back(foe_reply(HDR_LEN, OP_BUSY, 32'd0));
    events_queued.push_back(foe_reply(full_len(), OP_ACK, 32'd0));
    events_queued.push_back(control_event(REQ_SENT));
    events_queued.push_back(foe_reply(full_len(), OP_BUSY, 32'hFFFF_FFFF));
    events_queued.push_back(foe_reply(HDR_LEN, OP_ACK, 32'd1));
    events_queued.push_back(make_event(REQ_REPLY, 1'b0, 4'h0, HDR_LEN, OP_ERROR, $urandom));
    events_queued.push_back(foe_reply(16'h7FFF, OP_ACK, 32'd2));
    gen_pkt = 32'd3;
    drain();
    set_config(1'b1, 32'd0, 16'd16, 16'd16);
    events_queued.push_back(foe_reply(full_len(), OP_DATA, 32'd4));
    events_queued.push_back(foe_reply(HDR_LEN, OP_BUSY, $urandom));
    events_queued.push_back(control_event(REQ_SENT));
    events_queued.push_back(foe_reply(full_len(), OP_DATA, 32'd5));
    events_queued.push_back(make_event(REQ_REPLY, 1'b1, MBX_TYPE_FOE, full_len(), OP_DATA,
                                       32'd6));
    gen_pkt = 32'd5;
    drain();

    // long running transfer in both directions, nothing that ends it
    for (int ph = 0; ph < 6; ph++) begin
      rm = (ph % 2) == 1;
      fs = rm ? ((ph == 1) ? 32'd0 : $urandom)
              : $urandom_range(32'hFFFF_FFFF, 32'hF000_0000);
      set_config(rm, fs, pick_mbx_size(), pick_mbx_size());
      counted = 0;
      while (counted < RUN_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
          events_queued.push_back(noise_event());
        end else begin
          counted++;
          if (pick < 55) begin
            if (rm) events_queued.push_back(foe_reply(full_len(), OP_DATA, gen_pkt + 32'd1));
            else events_queued.push_back(foe_reply(valid_len(), OP_ACK, gen_pkt));
            gen_pkt = gen_pkt + 32'd1;
          end else if (pick < 75) begin
            events_queued.push_back(foe_reply(valid_len(), OP_BUSY, $urandom));
          end else begin
            events_queued.push_back(control_event(REQ_SENT));
          end
        end
      end
      drain();
    end

    // faults that only set the pending status, no sent notices in these phases
    for (int ph = 0; ph < 2; ph++) begin
      rm = ph == 1;
      set_config(rm, $urandom_range(32'hFFFF_FFFF, 32'hF000_0000), pick_mbx_size(),
                 pick_mbx_size());
      counted = 0;
      while (counted < 30) begin
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          events_queued.push_back(noise_event());
        end else begin
          counted++;
          if (pick < 35) begin
            len = (rm && $urandom_range(0, 1)) ? 16'($urandom_range(full_len() - 1, HDR))
                                               : full_len();
            if (rm) events_queued.push_back(foe_reply(len, OP_DATA, gen_pkt + 32'd1));
            else events_queued.push_back(foe_reply(valid_len(), OP_ACK, gen_pkt));
            gen_pkt = gen_pkt + 32'd1;
          end else if (pick < 55) begin
            if (rm) events_queued.push_back(foe_reply(valid_len(), OP_DATA,
                        (gen_pkt + 32'd1) ^ (32'd1 << $urandom_range(0, 31))));
            else events_queued.push_back(foe_reply(valid_len(), OP_ACK,
                        gen_pkt ^ (32'd1 << $urandom_range(0, 31))));
          end else if (pick < 75) begin
            if ($urandom_range(0, 1)) begin
              op = rm ? OP_ACK : OP_DATA;
            end else begin
              do op = 8'($urandom);
              while (op == OP_BUSY || op == OP_ERROR || op == (rm ? OP_DATA : OP_ACK));
            end
            events_queued.push_back(foe_reply(valid_len(), op, $urandom));
          end else begin
            events_queued.push_back(foe_reply(valid_len(), OP_BUSY, $urandom));
          end
        end
      end
      drain();
    end

    // one way of finishing per run
    ending = $urandom_range(0, 3);
    if (ending == 3) begin
      // offset already past the new file size: empty last chunk, then success
      set_config(1'b0, 32'd0, 16'd128, 16'd128);
      events_queued.push_back(foe_reply(valid_len(), OP_ACK, gen_pkt));
      gen_pkt = gen_pkt + 32'd1;
      events_queued.push_back(foe_reply(valid_len(), OP_ACK, gen_pkt));
    end else begin
      if ($urandom_range(0, 1)) begin
        events_queued.push_back(control_event(REQ_CANCEL));
        if ($urandom_range(0, 1))
          events_queued.push_back(foe_reply(valid_len(), OP_BUSY, $urandom));
      end
      case (ending)
        0: events_queued.push_back(control_event(REQ_SENT));
        1: events_queued.push_back(foe_reply(valid_len(), OP_ERROR, $urandom));
        default: begin
          len = $urandom_range(0, 1) ? 16'($urandom_range(HDR - 1, 0))
                                     : 16'($urandom_range(65535, 32'(full_len()) + 1));
          events_queued.push_back(foe_reply(len, $urandom_range(0, 1) ? OP_ERROR : OP_BUSY,
                                            $urandom));
        end
      endcase
    end

    // after the finish: replies are ignored, notices still report the status
    counted = 0;
    while (counted < 40) begin
      pick = $urandom_range(0, 99);
      counted++;
      if (pick < 30) begin
        events_queued.push_back(make_event(REQ_REPLY, 1'($urandom_range(0, 1)),
                                           $urandom_range(0, 3) ? MBX_TYPE_FOE : 4'($urandom),
                                           16'($urandom), 8'($urandom), $urandom));
      end else if (pick < 60) begin
        events_queued.push_back(foe_reply(valid_len(), 8'($urandom_range(3, 6)), $urandom));
      end else if (pick < 80) begin
        events_queued.push_back(control_event(REQ_SENT));
      end else if (pick < 90) begin
        events_queued.push_back(control_event(REQ_CANCEL));
      end else begin
        events_queued.push_back(noise_event());
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0) $display("foe_transfer_engine: match");
    else $display("foe_transfer_engine: mismatch");
    $finish;
  end

endmodule
